// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by ordered_list_engine.
// Needs signals clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define OLE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked on every clock edge outside reset.
`define OLE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked outside reset.
`define OLE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/olist_pkg.sv =====
// Package for the ordered list engine: sizes, opcodes, walker codes and types.
// No dependencies.
`default_nettype none

package olist_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int POS_W  = 6;
    localparam int DATA_W = 32;
    localparam int OP_W   = 3;

    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
    localparam logic [OP_W-1:0] OP_CHANGE = 3'd2;
    localparam logic [OP_W-1:0] OP_SEARCH = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

    localparam logic [1:0] WK_INS = 2'd0;
    localparam logic [1:0] WK_DEL = 2'd1;
    localparam logic [1:0] WK_CHG = 2'd2;
    localparam logic [1:0] WK_SRC = 2'd3;

    localparam logic [DATA_W-1:0] NOT_FOUND = '1;

    typedef struct packed {
        logic              go;
        logic [1:0]        kind;
        logic [CNT_W-1:0]  pos;
        logic [CNT_W-1:0]  cnt;
        logic [DATA_W-1:0] val;
    } walk_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] data;
    } walk_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/ordered_list_engine.sv =====
// Ordered list engine top level: command decode, count, result register.
// Depends on olist_pkg, olist_walk and assert_macros.svh.
//
//  channel   handshake       payload
//  command   start / busy    opcode, position, value
//  result    done (strobe)   status, result_value, length
//
// Clear, rejected and unknown commands: done one cycle after the transaction.
// Change reads and rewrites one entry; insert shifts entries at and above
// position up; delete shifts those above position down; search compares up to
// count entries, one move or compare per cycle through the single RAM read port.
// rst_n clears count and control; entry RAM holds no reset value.
// busy stays high while a walk is running; results cannot be stalled.
`default_nettype none

module ordered_list_engine (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [olist_pkg::OP_W-1:0]         opcode,
    input  wire logic [olist_pkg::POS_W-1:0]        position,
    input  wire logic signed [olist_pkg::DATA_W-1:0] value,
    output logic                                    done,
    output logic                                    status,
    output logic signed [olist_pkg::DATA_W-1:0]     result_value,
    output logic [olist_pkg::CNT_W-1:0]             length
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic                         state_reg, state_next;
    logic [olist_pkg::CNT_W-1:0]  count_reg, count_next;
    logic                         done_reg, done_next;
    logic                         status_reg, status_next;
    logic [olist_pkg::DATA_W-1:0] result_reg, result_next;
    logic [olist_pkg::CNT_W-1:0]  length_reg, length_next;

    logic                         accept;
    logic [olist_pkg::CNT_W-1:0]  pos_ext;
    olist_pkg::walk_req_t         req;
    olist_pkg::walk_rsp_t         rsp;

    assign busy    = (state_reg == ST_WALK);
    assign accept  = start && !busy;
    assign pos_ext = olist_pkg::CNT_W'(position);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        result_next = result_reg;
        length_next = length_reg;
        req.go      = 1'b0;
        req.kind    = olist_pkg::WK_SRC;
        req.pos     = pos_ext;
        req.cnt     = count_reg;
        req.val     = value;
        if (accept)
        begin
            unique case (opcode)
                olist_pkg::OP_INSERT:
                begin
                    if ((pos_ext <= count_reg) &&
                        (count_reg != olist_pkg::CNT_W'(olist_pkg::DEPTH)))
                    begin
                        req.go     = 1'b1;
                        req.kind   = olist_pkg::WK_INS;
                        count_next = count_reg + olist_pkg::CNT_W'(1);
                        state_next = ST_WALK;
                    end
                end
                olist_pkg::OP_DELETE:
                begin
                    if (pos_ext < count_reg)
                    begin
                        req.go     = 1'b1;
                        req.kind   = olist_pkg::WK_DEL;
                        count_next = count_reg - olist_pkg::CNT_W'(1);
                        state_next = ST_WALK;
                    end
                end
                olist_pkg::OP_CHANGE:
                begin
                    if (pos_ext < count_reg)
                    begin
                        req.go     = 1'b1;
                        req.kind   = olist_pkg::WK_CHG;
                        state_next = ST_WALK;
                    end
                end
                olist_pkg::OP_SEARCH:
                begin
                    if (count_reg != '0)
                    begin
                        req.go     = 1'b1;
                        req.kind   = olist_pkg::WK_SRC;
                        state_next = ST_WALK;
                    end
                end
                olist_pkg::OP_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                end
            endcase
            if (!req.go)
            begin
                // resolved without touching the RAM
                done_next   = 1'b1;
                length_next = count_next;
                status_next = !((opcode == olist_pkg::OP_CLEAR) ||
                                (opcode == olist_pkg::OP_SEARCH));
                result_next = (opcode == olist_pkg::OP_SEARCH) ?
                              olist_pkg::NOT_FOUND : '0;
            end
        end
        else if ((state_reg == ST_WALK) && rsp.done)
        begin
            state_next  = ST_IDLE;
            done_next   = 1'b1;
            status_next = 1'b0;
            result_next = rsp.data;
            length_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        result_reg <= result_next;
        length_reg <= length_next;
    end

    olist_walk u_walk (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    assign done         = done_reg;
    assign status       = status_reg;
    assign result_value = result_reg;
    assign length       = length_reg;

`include "assert_macros.svh"

    `OLE_ASSERT(a_count_max, count_reg <= olist_pkg::CNT_W'(olist_pkg::DEPTH), "count above depth")
    `OLE_ASSERT_IMP(a_walk_owned, rsp.done, state_reg == ST_WALK, "walk finished while idle")
    `OLE_ASSERT_NXT(a_walk_result, (state_reg == ST_WALK) && rsp.done, done && !busy, "walk result lost")
    `OLE_ASSERT_NXT(a_quick_result, accept && !req.go, done && !busy, "immediate result missing")

endmodule

`default_nettype wire

// ===== rtl/core/olist_walk.sv =====
// Entry memory and the sequencer that shifts, changes and searches it.
// Depends on olist_pkg.
`default_nettype none

module olist_walk (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire olist_pkg::walk_req_t req,
    output olist_pkg::walk_rsp_t      rsp
);

    logic [olist_pkg::DATA_W-1:0] mem [olist_pkg::DEPTH];
    logic [olist_pkg::DATA_W-1:0] rdata_reg;

    logic                         run_reg, run_next;
    logic                         pend_reg, pend_next;
    logic [olist_pkg::CNT_W-1:0]  idx_reg, idx_next;
    logic [olist_pkg::ADDR_W-1:0] tgt_reg, tgt_next;
    logic [1:0]                   kind_reg;
    logic [olist_pkg::CNT_W-1:0]  pos_reg;
    logic [olist_pkg::CNT_W-1:0]  cnt_reg;
    logic [olist_pkg::DATA_W-1:0] val_reg;

    logic                         rd_en, wr_en;
    logic [olist_pkg::ADDR_W-1:0] rd_addr, wr_addr;
    logic [olist_pkg::DATA_W-1:0] wr_data;
    logic [olist_pkg::CNT_W-1:0]  idx_dec, idx_inc, init_idx;

    assign idx_dec = idx_reg - olist_pkg::CNT_W'(1);
    assign idx_inc = idx_reg + olist_pkg::CNT_W'(1);

    always_comb
    begin
        unique case (req.kind)
            olist_pkg::WK_INS: init_idx = req.cnt;
            olist_pkg::WK_DEL: init_idx = req.pos + olist_pkg::CNT_W'(1);
            olist_pkg::WK_CHG: init_idx = req.pos;
            olist_pkg::WK_SRC: init_idx = '0;
            default:           init_idx = '0;
        endcase
    end

    always_comb
    begin
        run_next  = run_reg;
        pend_next = 1'b0;
        idx_next  = idx_reg;
        tgt_next  = tgt_reg;
        rd_en     = 1'b0;
        rd_addr   = idx_reg[olist_pkg::ADDR_W-1:0];
        wr_en     = 1'b0;
        wr_addr   = tgt_reg;
        wr_data   = rdata_reg;
        rsp.done  = 1'b0;
        rsp.data  = '0;
        if (req.go)
        begin
            run_next = 1'b1;
            idx_next = init_idx;
        end
        else if (run_reg)
        begin
            unique case (kind_reg)
                olist_pkg::WK_INS:
                begin
                    wr_en = pend_reg;
                    if (idx_reg > pos_reg)
                    begin
                        rd_en     = 1'b1;
                        rd_addr   = idx_dec[olist_pkg::ADDR_W-1:0];
                        tgt_next  = idx_reg[olist_pkg::ADDR_W-1:0];
                        pend_next = 1'b1;
                        idx_next  = idx_dec;
                    end
                    else if (!pend_reg)
                    begin
                        wr_en    = 1'b1;
                        wr_addr  = pos_reg[olist_pkg::ADDR_W-1:0];
                        wr_data  = val_reg;
                        rsp.done = 1'b1;
                        run_next = 1'b0;
                    end
                end
                olist_pkg::WK_DEL:
                begin
                    wr_en = pend_reg;
                    if (idx_reg < cnt_reg)
                    begin
                        rd_en     = 1'b1;
                        rd_addr   = idx_reg[olist_pkg::ADDR_W-1:0];
                        tgt_next  = idx_dec[olist_pkg::ADDR_W-1:0];
                        pend_next = 1'b1;
                        idx_next  = idx_inc;
                    end
                    else if (!pend_reg)
                    begin
                        rsp.done = 1'b1;
                        run_next = 1'b0;
                    end
                end
                olist_pkg::WK_CHG:
                begin
                    if (!pend_reg)
                    begin
                        rd_en     = 1'b1;
                        rd_addr   = idx_reg[olist_pkg::ADDR_W-1:0];
                        tgt_next  = idx_reg[olist_pkg::ADDR_W-1:0];
                        pend_next = 1'b1;
                    end
                    else
                    begin
                        wr_en    = 1'b1;
                        wr_data  = val_reg;
                        rsp.done = 1'b1;
                        rsp.data = rdata_reg;
                        run_next = 1'b0;
                    end
                end
                olist_pkg::WK_SRC:
                begin
                    if (pend_reg && (rdata_reg == val_reg))
                    begin
                        rsp.done = 1'b1;
                        rsp.data = olist_pkg::DATA_W'(tgt_reg);
                        run_next = 1'b0;
                    end
                    else if (idx_reg < cnt_reg)
                    begin
                        rd_en     = 1'b1;
                        rd_addr   = idx_reg[olist_pkg::ADDR_W-1:0];
                        tgt_next  = idx_reg[olist_pkg::ADDR_W-1:0];
                        pend_next = 1'b1;
                        idx_next  = idx_inc;
                    end
                    else if (!pend_reg)
                    begin
                        rsp.done = 1'b1;
                        rsp.data = olist_pkg::NOT_FOUND;
                        run_next = 1'b0;
                    end
                end
                default:
                begin
                    run_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            pend_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        tgt_reg <= tgt_next;
        if (req.go)
        begin
            kind_reg <= req.kind;
            pos_reg  <= req.pos;
            cnt_reg  <= req.cnt;
            val_reg  <= req.val;
        end
    end

    // synchronous RAM, one read and one write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== verif/ordered_list_engine_tb.sv =====
// Testbench for ordered_list_engine: directed and random list commands, a
// scoreboard with its own list state predicts each result. Depends on olist_pkg.
`timescale 1ns / 100ps

module ordered_list_engine_tb;
    import olist_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED_LO = OP_W'(OP_CLEAR + 1);
    localparam logic [OP_W-1:0] OP_UNUSED_HI = '1;
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int DRAIN_CYCLES = DEPTH + 16;
    localparam int PHASE_ITEMS  = 200;
    localparam int MAX_REPORTS  = 10;

    typedef enum int {MIX_FILL, MIX_BALANCED, MIX_DRAIN, MIX_LOOKUP} mix_t;

    typedef struct {
        logic              status;
        logic [DATA_W-1:0] data;
        logic [CNT_W-1:0]  len;
    } list_result_t;

    class list_scoreboard;
        logic signed [DATA_W-1:0] items[DEPTH];
        int                       size;
        list_result_t             pending[$];
        int                       mismatches;

        function new();
            size = 0;
            mismatches = 0;
        endfunction

        function void note_command(input logic [OP_W-1:0] op,
                                   input logic [POS_W-1:0] pos,
                                   input logic signed [DATA_W-1:0] val);
            list_result_t r;
            int p;
            int i;
            logic found;
            r.status = 1'b0;
            r.data = '0;
            p = int'(pos);
            found = 1'b0;
            case (op)
                OP_INSERT:
                    if (p > size || size >= DEPTH)
                        r.status = 1'b1;
                    else
                    begin
                        for (i = size; i > p; i--)
                            items[i] = items[i-1];
                        items[p] = val;
                        size++;
                    end
                OP_DELETE:
                    if (size == 0 || p >= size)
                        r.status = 1'b1;
                    else
                    begin
                        for (i = p; i + 1 < size; i++)
                            items[i] = items[i+1];
                        size--;
                    end
                OP_CHANGE:
                    if (size == 0 || p >= size)
                        r.status = 1'b1;
                    else
                    begin
                        r.data = items[p];
                        items[p] = val;
                    end
                OP_SEARCH:
                begin
                    r.data = NOT_FOUND;
                    for (i = 0; i < size; i++)
                        if (!found && items[i] == val)
                        begin
                            r.data = i;
                            found = 1'b1;
                        end
                end
                OP_CLEAR:
                    size = 0;
                default:
                    r.status = 1'b1;
            endcase
            r.len = size[CNT_W-1:0];
            pending.push_back(r);
        endfunction

        function void check_result(input logic st, input logic [DATA_W-1:0] data,
                                   input logic [CNT_W-1:0] len);
            list_result_t exp_r;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result with no transaction outstanding: ",
                             "status %0b data %h len %0d", $realtime, st, data, len);
            end
            else
            begin
                exp_r = pending.pop_front();
                if (st !== exp_r.status || data !== exp_r.data || len !== exp_r.len)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: mismatch: exp status %0b data %h len %0d, got %0b %h %0d",
                                 $realtime, exp_r.status, exp_r.data, exp_r.len, st, data, len);
                end
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [OP_W-1:0]          opcode = '0;
    logic [POS_W-1:0]         position = '0;
    logic signed [DATA_W-1:0] value = '0;
    logic                     done;
    logic                     status;
    logic signed [DATA_W-1:0] result_value;
    logic [CNT_W-1:0]         length;

    list_scoreboard tracker;
    int             cycles = 0;
    int             gapless_left = 0;

    ordered_list_engine dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .position     (position),
        .value        (value),
        .done         (done),
        .status       (status),
        .result_value (result_value),
        .length       (length)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("ordered_list_engine_tb NOT OK");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && done)
            tracker.check_result(status, result_value, length);

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (gapless_left > 0)
        begin
            gapless_left--;
            return 0;
        end
        if (r < 2)
        begin
            gapless_left = $urandom_range(10, 40);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    task automatic send_command(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                                input logic signed [DATA_W-1:0] val);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        opcode <= op;
        position <= pos;
        value <= val;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        tracker.note_command(op, pos, val);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return $signed($urandom_range(0, 15)) - 8;
        if (r < 60)
            case ($urandom_range(0, 3))
                0: return 32'sh8000_0000;
                1: return 32'sh7FFF_FFFF;
                2: return '0;
                default: return '1;
            endcase
        return $urandom;
    endfunction

    task automatic random_command(input mix_t mix);
        int w_ins, w_del, w_chg, w_src, w_clr;
        int r, sz;
        logic [OP_W-1:0] op;
        logic [POS_W-1:0] pos;
        logic signed [DATA_W-1:0] val;
        case (mix)
            MIX_FILL:
            begin
                w_ins = 65; w_del = 10; w_chg = 10; w_src = 12; w_clr = 0;
            end
            MIX_BALANCED:
            begin
                w_ins = 30; w_del = 25; w_chg = 20; w_src = 20; w_clr = 2;
            end
            MIX_DRAIN:
            begin
                w_ins = 10; w_del = 65; w_chg = 10; w_src = 10; w_clr = 2;
            end
            default:
            begin
                w_ins = 25; w_del = 15; w_chg = 15; w_src = 40; w_clr = 2;
            end
        endcase
        sz = tracker.size;
        r = $urandom_range(0, 99);
        if (r < w_ins)
            op = OP_INSERT;
        else if (r < w_ins + w_del)
            op = OP_DELETE;
        else if (r < w_ins + w_del + w_chg)
            op = OP_CHANGE;
        else if (r < w_ins + w_del + w_chg + w_src)
            op = OP_SEARCH;
        else if (r < w_ins + w_del + w_chg + w_src + w_clr)
            op = OP_CLEAR;
        else
            op = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));

        if ($urandom_range(0, 99) < 15)
            pos = POS_W'($urandom);
        else if (op == OP_INSERT)
            pos = (sz >= DEPTH) ? POS_W'($urandom) : POS_W'($urandom_range(0, sz));
        else if (sz > 0)
            pos = POS_W'($urandom_range(0, sz - 1));
        else
            pos = POS_W'($urandom);

        if (op == OP_SEARCH && sz > 0 && $urandom_range(0, 99) < 60)
            val = tracker.items[$urandom_range(0, sz - 1)];
        else
            val = pick_value();
        send_command(op, pos, val);
    endtask

    task automatic run_directed();
        send_command(OP_SEARCH, '0, '0);
        send_command(OP_DELETE, '0, '0);
        send_command(OP_CHANGE, '0, '1);
        send_command(OP_INSERT, 6'd1, 32'sd7);
        send_command(OP_INSERT, '0, 32'sh7FFF_FFFF);
        send_command(OP_INSERT, '0, 32'sh8000_0000);
        send_command(OP_INSERT, 6'd2, '1);
        send_command(OP_INSERT, 6'd1, '0);
        send_command(OP_SEARCH, '0, '1);
        send_command(OP_SEARCH, '0, 32'sd12345);
        send_command(OP_CHANGE, 6'd2, 32'sd5);
        send_command(OP_CHANGE, 6'd4, 32'sd9);
        send_command(OP_DELETE, 6'd4, '0);
        send_command(OP_DELETE, '0, '0);
        send_command(OP_DELETE, 6'd2, '0);
        send_command(OP_INSERT, '1, '1);
        send_command(OP_UNUSED_LO, 6'd1, 32'sd1);
        send_command(OP_W'(OP_UNUSED_LO + 1), '0, '0);
        send_command(OP_UNUSED_HI, '1, '1);
        send_command(OP_SEARCH, '0, 32'sd5);
        send_command(OP_CLEAR, '1, '1);
        send_command(OP_SEARCH, '0, 32'sd5);
        send_command(OP_INSERT, '0, '0);
        send_command(OP_DELETE, '1, '1);
    endtask

    initial
    begin
        mix_t plan[7];
        plan = '{MIX_FILL, MIX_BALANCED, MIX_DRAIN, MIX_FILL, MIX_LOOKUP, MIX_BALANCED,
                 MIX_FILL};
        tracker = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        foreach (plan[k])
            repeat (PHASE_ITEMS) random_command(plan[k]);
        start <= 1'b0;
        while (tracker.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending.size() == 0)
            $display("ordered_list_engine_tb OK");
        else
            $display("ordered_list_engine_tb NOT OK");
        $finish;
    end

endmodule
